[design/set_assoc_cache_lru_lookup_defines.svh]
// ---------------------------------------------------------------------------
// set_assoc_cache_lru_lookup_defines
// Assertion macros shared by the cache directory RTL.
// ---------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_LRU_LOOKUP_DEFINES_SVH
`define SET_ASSOC_CACHE_LRU_LOOKUP_DEFINES_SVH

`ifndef SYNTHESIS
// Property holds on every clock edge outside reset.
`define SACL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Antecedent on one edge implies consequent on the next edge.
`define SACL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SACL_ASSERT(lbl, prop, msg)
`define SACL_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[design/sacl_pkg.sv]
// ---------------------------------------------------------------------------
// sacl_pkg
// Constants, row layout and helpers for the set-associative cache directory.
// ---------------------------------------------------------------------------
`default_nettype none

package sacl_pkg;

  localparam int MAX_SET_BITS = 6;
  localparam int MAX_WAYS     = 8;

  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int SET_W    = MAX_SET_BITS;
  localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WCNT_W   = $clog2(MAX_WAYS + 1);
  localparam int TREE_N   = 1 << WAY_W;

  localparam int ADDR_W   = 64;
  localparam int TAG_W    = 62;
  localparam int STAMP_W  = 32;
  localparam int CNT_W    = 32;
  localparam int WAYOUT_W = 3;

  localparam int SBITS_W  = 3;
  localparam int OFFS_W   = 5;
  localparam int WAYS_W   = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SET_INDEX_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE    = 2'd2;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // one directory row holds every way of a set
  typedef struct packed {
    logic [MAX_WAYS-1:0]              valid;
    logic [MAX_WAYS-1:0][TAG_W-1:0]   tag;
    logic [MAX_WAYS-1:0][STAMP_W-1:0] stamp;
  } row_t;

  // lookup decision for one access
  typedef struct packed {
    logic             hit;
    logic             evict;
    logic [WAY_W-1:0] way;
  } sel_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

endpackage

`default_nettype wire

[design/sacl_way_select.sv]
// ---------------------------------------------------------------------------
// sacl_way_select
// Tag match, first free way and LRU victim search over one directory row.
// ---------------------------------------------------------------------------
`default_nettype none

module sacl_way_select (
  input  wire sacl_pkg::row_t                 row,
  input  wire logic [sacl_pkg::TAG_W-1:0]     tag,
  input  wire logic [sacl_pkg::WCNT_W-1:0]    ways_eff,
  output sacl_pkg::sel_t                      sel
);
  import sacl_pkg::*;

  logic [MAX_WAYS-1:0] way_en;
  logic [MAX_WAYS-1:0] match;
  logic [MAX_WAYS-1:0] free;
  logic                hit_found;
  logic [WAY_W-1:0]    hit_way;
  logic                free_found;
  logic [WAY_W-1:0]    free_way;

  logic [2*TREE_N-2:0] nd_en;
  logic [STAMP_W-1:0]  nd_stamp [2*TREE_N-1];
  logic [WAY_W-1:0]    nd_idx   [2*TREE_N-1];

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      way_en[w] = WCNT_W'(w) < ways_eff;
      match[w]  = way_en[w] && row.valid[w] && (row.tag[w] == tag);
      free[w]   = way_en[w] && !row.valid[w];
    end
  end

  // lowest index wins
  always_comb begin
    hit_found  = 1'b0;
    hit_way    = '0;
    free_found = 1'b0;
    free_way   = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (match[w] && !hit_found) begin
        hit_found = 1'b1;
        hit_way   = WAY_W'(w);
      end
      if (free[w] && !free_found) begin
        free_found = 1'b1;
        free_way   = WAY_W'(w);
      end
    end
  end

  // min-stamp tree; left subtrees hold lower ways, so ties keep the left side
  always_comb begin
    for (int i = 0; i < TREE_N; i++) begin
      if (i < MAX_WAYS) begin
        nd_en[TREE_N-1+i]    = way_en[i];
        nd_stamp[TREE_N-1+i] = row.stamp[i];
      end else begin
        nd_en[TREE_N-1+i]    = 1'b0;
        nd_stamp[TREE_N-1+i] = '0;
      end
      nd_idx[TREE_N-1+i] = WAY_W'(i);
    end
    for (int n = TREE_N - 2; n >= 0; n--) begin
      if (nd_en[2*n+2] && (!nd_en[2*n+1] || (nd_stamp[2*n+2] < nd_stamp[2*n+1]))) begin
        nd_stamp[n] = nd_stamp[2*n+2];
        nd_idx[n]   = nd_idx[2*n+2];
      end else begin
        nd_stamp[n] = nd_stamp[2*n+1];
        nd_idx[n]   = nd_idx[2*n+1];
      end
      nd_en[n] = nd_en[2*n+1] || nd_en[2*n+2];
    end
  end

  always_comb begin
    sel.hit   = hit_found;
    sel.evict = !hit_found && !free_found;
    if (hit_found) begin
      sel.way = hit_way;
    end else if (free_found) begin
      sel.way = free_way;
    end else begin
      sel.way = nd_idx[0];
    end
  end

endmodule

`default_nettype wire

[design/set_assoc_cache_lru_lookup.sv]
// ---------------------------------------------------------------------------
// set_assoc_cache_lru_lookup
// Set-associative tag directory with timestamp LRU replacement.
// ---------------------------------------------------------------------------
// Usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   set_index_bits, offset_bits and ways_in_use; always ready, write only
//   while no access is in flight.
//   in channel takes one access address per item; out channel returns one
//   result per item: hit/miss/eviction flags, way used and running totals.
//   The item's row read and set/tag fields are registered when it is
//   taken; its result is registered at commit, once the output register
//   is free. The directory row of the set is read from a synchronous
//   memory, then compared and written back; the next item is taken once
//   that write has been issued. A result waiting on out_ready does not
//   block the next item's row read; the write-back of that item waits
//   until the output register frees up.
//   Reset: all rows read as invalid (per-set row flags cleared at once),
//   stamp clock and totals go to zero, registers return to 1/1/1.
//   No clearing pass is needed, so items are taken right after reset.
// ---------------------------------------------------------------------------
`default_nettype none
`include "set_assoc_cache_lru_lookup_defines.svh"

module set_assoc_cache_lru_lookup (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire  [sacl_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire  [sacl_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  wire                                   in_valid,
  output logic                                  in_ready,
  input  wire  [sacl_pkg::ADDR_W-1:0]           address,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output logic                                  hit,
  output logic                                  miss,
  output logic                                  eviction,
  output logic [sacl_pkg::WAYOUT_W-1:0]         way_used,
  output logic [sacl_pkg::CNT_W-1:0]            hit_total,
  output logic [sacl_pkg::CNT_W-1:0]            miss_total,
  output logic [sacl_pkg::CNT_W-1:0]            eviction_total
);
  import sacl_pkg::*;

  localparam logic S_IDLE   = 1'b0;
  localparam logic S_LOOKUP = 1'b1;

  logic                  state;
  logic [SBITS_W-1:0]    set_index_bits;
  logic [OFFS_W-1:0]     offset_bits;
  logic [WAYS_W-1:0]     ways_in_use;

  logic [SBITS_W:0]      sb_eff;
  logic [WCNT_W-1:0]     ways_eff;
  logic [ADDR_W-1:0]     set_shift;
  logic [ADDR_W-1:0]     tag_shift;
  logic [SET_W-1:0]      acc_set;
  logic [TAG_W-1:0]      acc_tag;

  logic [SET_W-1:0]      look_set;
  logic [TAG_W-1:0]      look_tag;

  row_t                  dir_mem [NUM_SETS];
  row_t                  rd_raw;
  logic                  rd_ok;
  logic [NUM_SETS-1:0]   row_ok;
  row_t                  cur_row;
  row_t                  wr_row;
  sel_t                  sel;

  logic                  accept;
  logic                  commit;
  logic [STAMP_W-1:0]    access_clock;
  logic [CNT_W-1:0]      hits_seen;
  logic [CNT_W-1:0]      misses_seen;
  logic [CNT_W-1:0]      evictions_seen;
  logic [CNT_W-1:0]      hits_seen_next;
  logic [CNT_W-1:0]      misses_seen_next;
  logic [CNT_W-1:0]      evictions_seen_next;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign commit    = (state == S_LOOKUP) && (!out_valid || out_ready);

  // clamp registers to the supported range
  always_comb begin
    if ({1'b0, set_index_bits} > (SBITS_W + 1)'(MAX_SET_BITS)) begin
      sb_eff = (SBITS_W + 1)'(MAX_SET_BITS);
    end else begin
      sb_eff = {1'b0, set_index_bits};
    end
    if (ways_in_use == '0) begin
      ways_eff = WCNT_W'(1);
    end else if ({1'b0, ways_in_use} > (WAYS_W + 1)'(MAX_WAYS)) begin
      ways_eff = WCNT_W'(MAX_WAYS);
    end else begin
      ways_eff = WCNT_W'(ways_in_use);
    end
  end

  // address split
  always_comb begin
    set_shift = address >> offset_bits;
    tag_shift = address >> ((OFFS_W + 2)'(offset_bits) + (OFFS_W + 2)'(sb_eff));
    acc_set   = set_shift[SET_W-1:0] & ~({SET_W{1'b1}} << sb_eff);
    acc_tag   = tag_shift[TAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      set_index_bits <= SBITS_W'(1);
      offset_bits    <= OFFS_W'(1);
      ways_in_use    <= WAYS_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SET_INDEX_BITS: set_index_bits <= cfg_data[SBITS_W-1:0];
        REG_OFFSET_BITS:    offset_bits    <= cfg_data[OFFS_W-1:0];
        REG_WAYS_IN_USE:    ways_in_use    <= cfg_data[WAYS_W-1:0];
        default:            ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE:   if (accept) state <= S_LOOKUP;
        S_LOOKUP: if (commit) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      look_set <= acc_set;
      look_tag <= acc_tag;
    end
  end

  // directory memory: one read port at accept, one write port at commit
  always_ff @(posedge clk) begin
    if (commit) begin
      dir_mem[look_set] <= wr_row;
    end
    if (accept) begin
      rd_raw <= dir_mem[acc_set];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_ok <= '0;
      rd_ok  <= 1'b0;
    end else begin
      if (commit) begin
        row_ok[look_set] <= 1'b1;
      end
      if (accept) begin
        rd_ok <= row_ok[acc_set];
      end
    end
  end

  // a row never written since reset reads as all zero
  assign cur_row = rd_ok ? rd_raw : '0;

  sacl_way_select u_sel (
    .row      (cur_row),
    .tag      (look_tag),
    .ways_eff (ways_eff),
    .sel      (sel)
  );

  always_comb begin
    wr_row = cur_row;
    if (!sel.hit) begin
      wr_row.valid[sel.way] = 1'b1;
      wr_row.tag[sel.way]   = look_tag;
    end
    wr_row.stamp[sel.way] = access_clock;
  end

  always_comb begin
    hits_seen_next      = sel.hit ? sat_inc(hits_seen) : hits_seen;
    misses_seen_next    = sel.hit ? misses_seen : sat_inc(misses_seen);
    evictions_seen_next = sel.evict ? sat_inc(evictions_seen) : evictions_seen;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      access_clock   <= '0;
      hits_seen      <= '0;
      misses_seen    <= '0;
      evictions_seen <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (commit) begin
        access_clock   <= access_clock + STAMP_W'(1);
        hits_seen      <= hits_seen_next;
        misses_seen    <= misses_seen_next;
        evictions_seen <= evictions_seen_next;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      hit            <= sel.hit;
      miss           <= !sel.hit;
      eviction       <= sel.evict;
      way_used       <= WAYOUT_W'(sel.way);
      hit_total      <= hits_seen_next;
      miss_total     <= misses_seen_next;
      eviction_total <= evictions_seen_next;
    end
  end

  `SACL_ASSERT(a_hit_xor_miss, !out_valid || (hit != miss), "hit and miss not exclusive")
  `SACL_ASSERT(a_evict_on_miss, !out_valid || !(hit && eviction), "eviction flagged on a hit")
  `SACL_ASSERT(a_evict_le_miss, !out_valid || (eviction_total <= miss_total),
               "more evictions than misses")
  `SACL_ASSERT_NEXT(a_clock_step, commit,
                    access_clock == STAMP_W'($past(access_clock) + STAMP_W'(1)),
                    "stamp clock did not advance on commit")
  `SACL_ASSERT_NEXT(a_accept_lookup, accept, (state == S_LOOKUP) && !in_ready,
                    "accepted item did not enter lookup")

endmodule

`default_nettype wire

[test/tb_top.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the set-associative LRU tag directory. A queue of
// accesses, register writes and flow-control markers feeds a clocked driver.
// A clocked monitor keeps its own copy of the directory, predicts each result
// as the access is taken, and checks the results in order.
// ---------------------------------------------------------------------------
module tb_top;
  import sacl_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int HOLD_CYCLES  = 400;
  localparam int MAX_PRINTS   = 200;
  localparam int NUM_PHASES   = 26;
  localparam int PHASE_ITEMS  = 70;
  localparam int TAIL_CYCLES  = 20;

  typedef enum logic [1:0] {OP_ACCESS, OP_CONFIG, OP_DRAIN, OP_HOLD} op_kind_e;

  typedef struct {
    op_kind_e              kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [ADDR_W-1:0]     addr;
  } stim_op_t;

  typedef struct packed {
    logic                hit;
    logic                miss;
    logic                eviction;
    logic [WAYOUT_W-1:0] way;
    logic [CNT_W-1:0]    hits;
    logic [CNT_W-1:0]    misses;
    logic [CNT_W-1:0]    evictions;
  } lookup_res_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [ADDR_W-1:0]     address = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  hit;
  logic                  miss;
  logic                  eviction;
  logic [WAYOUT_W-1:0]   way_used;
  logic [CNT_W-1:0]      hit_total;
  logic [CNT_W-1:0]      miss_total;
  logic [CNT_W-1:0]      eviction_total;

  set_assoc_cache_lru_lookup u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .address        (address),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .hit            (hit),
    .miss           (miss),
    .eviction       (eviction),
    .way_used       (way_used),
    .hit_total      (hit_total),
    .miss_total     (miss_total),
    .eviction_total (eviction_total)
  );

  stim_op_t    op_q[$];
  lookup_res_t pending_results[$];
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  logic        hold_start = 1'b0;
  int unsigned gap_left;
  int unsigned burst_left;
  int unsigned hold_left;
  logic [15:0] rx_cycle;

  // shadow directory and registers
  logic [SBITS_W-1:0] m_set_bits;
  logic [OFFS_W-1:0]  m_offset_bits;
  logic [WAYS_W-1:0]  m_ways;
  logic               dir_valid [NUM_SETS][MAX_WAYS];
  logic [TAG_W-1:0]   dir_tag   [NUM_SETS][MAX_WAYS];
  logic [STAMP_W-1:0] dir_stamp [NUM_SETS][MAX_WAYS];
  logic [STAMP_W-1:0] stamp_clock;
  logic [CNT_W-1:0]   pred_hits;
  logic [CNT_W-1:0]   pred_misses;
  logic [CNT_W-1:0]   pred_evictions;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + CNT_W'(1);
  endfunction

  task automatic lru_lookup(input logic [ADDR_W-1:0] a, output lookup_res_t r);
    int                 sb;
    int                 nways;
    int                 s;
    int                 w;
    int                 pick;
    logic [ADDR_W-1:0]  shifted;
    logic [TAG_W-1:0]   tag;
    logic               found;
    logic               evict;
    logic [STAMP_W-1:0] oldest;
    sb = (m_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : int'(m_set_bits);
    nways = (m_ways == 0) ? 1 : ((m_ways > MAX_WAYS) ? MAX_WAYS : int'(m_ways));
    shifted = a >> (sb + int'(m_offset_bits));
    tag = shifted[TAG_W-1:0];
    shifted = (a >> m_offset_bits) & ((64'd1 << sb) - 64'd1);
    s = int'(shifted[SET_W-1:0]);
    found = 1'b0;
    evict = 1'b0;
    pick = 0;
    for (w = 0; w < nways; w++)
      if (!found && dir_valid[s][w] && dir_tag[s][w] == tag) begin
        found = 1'b1;
        pick = w;
      end
    r.hit  = found;
    r.miss = !found;
    if (found) begin
      pred_hits = bump(pred_hits);
    end else begin
      pred_misses = bump(pred_misses);
      for (w = 0; w < nways; w++)
        if (!found && !dir_valid[s][w]) begin
          found = 1'b1;
          pick = w;
        end
      // set full: replace smallest stamp, lowest way on a tie
      if (!found) begin
        oldest = dir_stamp[s][0];
        pick = 0;
        for (w = 1; w < nways; w++)
          if (dir_stamp[s][w] < oldest) begin
            oldest = dir_stamp[s][w];
            pick = w;
          end
        evict = 1'b1;
        pred_evictions = bump(pred_evictions);
      end
      dir_valid[s][pick] = 1'b1;
      dir_tag[s][pick] = tag;
    end
    dir_stamp[s][pick] = stamp_clock;
    stamp_clock = stamp_clock + STAMP_W'(1);
    r.eviction  = evict;
    r.way       = pick[WAYOUT_W-1:0];
    r.hits      = pred_hits;
    r.misses    = pred_misses;
    r.evictions = pred_evictions;
  endtask

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("%0t mismatch: %s", $time, what);
  endtask

  task automatic cmp_field(input string name, input logic [63:0] got, input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %0h, want %0h",
                                results_seen, name, got, want));
  endtask

  // driver: access and register channels, bursts with random gaps
  always @(posedge clk) begin : sender
    logic        nv_in;
    logic        nv_cfg;
    logic        nv_hold;
    int unsigned nsent;
    stim_op_t    op;
    if (rst) begin
      in_valid   <= 1'b0;
      cfg_valid  <= 1'b0;
      hold_start <= 1'b0;
      items_sent <= 0;
      gap_left   = 0;
      burst_left = 0;
    end else begin
      nv_in   = in_valid;
      nv_cfg  = cfg_valid;
      nv_hold = 1'b0;
      nsent   = items_sent;
      if (in_valid && in_ready) begin
        nv_in = 1'b0;
        nsent++;
      end
      if (cfg_valid && cfg_ready)
        nv_cfg = 1'b0;
      if (!nv_in && !nv_cfg) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (op_q.size() != 0) begin
          case (op_q[0].kind)
            OP_ACCESS: begin
              op = op_q.pop_front();
              nv_in = 1'b1;
              address <= op.addr;
              if (burst_left != 0) begin
                burst_left--;
              end else begin
                burst_left = $urandom_range(0, 15);
                if ($urandom_range(0, 2) == 0)
                  gap_left = 0;
                else if ($urandom_range(0, 7) == 0)
                  gap_left = $urandom_range(5, 30);
                else
                  gap_left = $urandom_range(1, 4);
              end
            end
            OP_CONFIG: begin
              // registers only change with nothing in flight
              if (nsent == results_seen) begin
                op = op_q.pop_front();
                nv_cfg = 1'b1;
                cfg_index <= op.idx;
                cfg_data  <= op.data;
              end
            end
            OP_DRAIN: begin
              if (nsent == results_seen)
                op = op_q.pop_front();
            end
            OP_HOLD: begin
              op = op_q.pop_front();
              nv_hold = 1'b1;
            end
            default: ;
          endcase
        end
      end
      in_valid   <= nv_in;
      cfg_valid  <= nv_cfg;
      hold_start <= nv_hold;
      items_sent <= nsent;
    end
  end

  // result side: rotating stall patterns plus one long hold-off
  always @(posedge clk) begin : receiver
    if (rst) begin
      out_ready <= 1'b0;
      hold_left = 0;
      rx_cycle  = '0;
    end else begin
      rx_cycle++;
      if (hold_start)
        hold_left = HOLD_CYCLES;
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (rx_cycle[8:6])
          3'd0, 3'd1: out_ready <= 1'b1;
          3'd2, 3'd3: out_ready <= 1'($urandom_range(0, 1));
          3'd4:       out_ready <= ($urandom_range(0, 3) == 0);
          3'd5:       out_ready <= (rx_cycle[1:0] != 2'd0);
          3'd6:       out_ready <= rx_cycle[2];
          default:    out_ready <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  // monitor: register writes, prediction on access, in-order result check
  always @(posedge clk) begin : monitor
    lookup_res_t got_r;
    lookup_res_t want_r;
    lookup_res_t pred_r;
    int          s;
    int          w;
    if (rst) begin
      m_set_bits    = 3'd1;
      m_offset_bits = 5'd1;
      m_ways        = 4'd1;
      for (s = 0; s < NUM_SETS; s++)
        for (w = 0; w < MAX_WAYS; w++) begin
          dir_valid[s][w] = 1'b0;
          dir_tag[s][w]   = '0;
          dir_stamp[s][w] = '0;
        end
      stamp_clock    = '0;
      pred_hits      = '0;
      pred_misses    = '0;
      pred_evictions = '0;
      results_seen <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SET_INDEX_BITS: m_set_bits    = cfg_data[SBITS_W-1:0];
          REG_OFFSET_BITS:    m_offset_bits = cfg_data[OFFS_W-1:0];
          REG_WAYS_IN_USE:    m_ways        = cfg_data[WAYS_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got_r = '{hit, miss, eviction, way_used, hit_total, miss_total, eviction_total};
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no access pending",
                                    results_seen));
        end else begin
          want_r = pending_results.pop_front();
          cmp_field("hit", got_r.hit, want_r.hit);
          cmp_field("miss", got_r.miss, want_r.miss);
          cmp_field("eviction", got_r.eviction, want_r.eviction);
          cmp_field("way_used", got_r.way, want_r.way);
          cmp_field("hit_total", got_r.hits, want_r.hits);
          cmp_field("miss_total", got_r.misses, want_r.misses);
          cmp_field("eviction_total", got_r.evictions, want_r.evictions);
        end
        results_seen <= results_seen + 1;
      end
      if (in_valid && in_ready) begin
        lru_lookup(address, pred_r);
        pending_results.push_back(pred_r);
      end
    end
  end

  task automatic push_access(input logic [ADDR_W-1:0] a);
    stim_op_t op;
    op = '{OP_ACCESS, '0, '0, a};
    op_q.push_back(op);
  endtask

  task automatic push_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    stim_op_t op;
    op = '{OP_CONFIG, idx, d, '0};
    op_q.push_back(op);
  endtask

  task automatic push_ctl(input op_kind_e kind);
    stim_op_t op;
    op = '{kind, '0, '0, '0};
    op_q.push_back(op);
  endtask

  function automatic logic [ADDR_W-1:0] compose_addr(input logic [ADDR_W-1:0] tag,
                                                      input int set_no, input int sh,
                                                      input int ob);
    logic [ADDR_W-1:0] low;
    low = {$urandom, $urandom} & ((64'd1 << ob) - 64'd1);
    return (tag << sh) | (64'(set_no) << ob) | low;
  endfunction

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] ext_sb [4] = '{5'd6, 5'd0, 5'd7, 5'd1};
    logic [CFG_DATA_W-1:0] ext_ob [4] = '{5'd16, 5'd1, 5'd31, 5'd0};
    logic [CFG_DATA_W-1:0] ext_wy [4] = '{5'd8, 5'd1, 5'd15, 5'd0};
    logic [CFG_DATA_W-1:0] sbd;
    logic [CFG_DATA_W-1:0] obd;
    logic [CFG_DATA_W-1:0] wyd;
    logic [ADDR_W-1:0]     tag_pool [16];
    int                    set_pool [4];
    int                    eff_sb;
    int                    eff_ob;
    int                    eff_wy;
    int                    nt;
    int                    ns;
    int                    ph;
    int                    k;

    // reset settings, one way: refill, hit, then thrash set 1
    push_access(64'd0);
    push_access(64'd0);
    push_access('1);
    push_access(64'd2);
    push_access('1);
    // single set, no offset: tag bits above 61 are dropped
    push_cfg(REG_SET_INDEX_BITS, 5'd0);
    push_cfg(REG_OFFSET_BITS, 5'd0);
    push_cfg(REG_WAYS_IN_USE, 5'd0);
    push_access(64'h8000_0000_0000_0005);
    push_access(64'h4000_0000_0000_0005);
    push_access(64'hC000_0000_0000_0005);
    push_access(64'h0000_0000_0000_0005);
    // out-of-range set bits and ways clamp to 6 and 8
    push_cfg(REG_SET_INDEX_BITS, 5'd7);
    push_cfg(REG_OFFSET_BITS, 5'd31);
    push_cfg(REG_WAYS_IN_USE, 5'd15);
    push_cfg(REG_UNUSED, 5'd3);
    for (k = 1; k <= 9; k++)
      push_access(compose_addr(64'(k), 63, 37, 31));
    push_access(compose_addr(64'd2, 63, 37, 31));
    push_access(compose_addr(64'd1, 63, 37, 31));
    sbd = 5'd7;
    obd = 5'd31;
    wyd = 5'd15;

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph < 4) begin
        sbd = ext_sb[ph];
        obd = ext_ob[ph];
        wyd = ext_wy[ph];
        push_cfg(REG_SET_INDEX_BITS, sbd);
        push_cfg(REG_OFFSET_BITS, obd);
        push_cfg(REG_WAYS_IN_USE, wyd);
      end else begin
        if ($urandom_range(0, 2) != 0) begin
          sbd = ($urandom_range(0, 5) == 0) ? 5'($urandom_range(0, 31))
                                            : 5'($urandom_range(0, 7));
          push_cfg(REG_SET_INDEX_BITS, sbd);
        end
        if ($urandom_range(0, 2) != 0) begin
          obd = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(17, 31))
                                            : 5'($urandom_range(0, 16));
          push_cfg(REG_OFFSET_BITS, obd);
        end
        if ($urandom_range(0, 2) != 0) begin
          wyd = ($urandom_range(0, 5) == 0) ? 5'($urandom_range(0, 31))
                                            : 5'($urandom_range(1, 8));
          push_cfg(REG_WAYS_IN_USE, wyd);
        end
        if (ph == 7)
          push_cfg(REG_UNUSED, 5'($urandom_range(0, 31)));
      end
      eff_sb = (sbd[2:0] > 6) ? 6 : int'(sbd[2:0]);
      eff_ob = int'(obd);
      eff_wy = (wyd[3:0] == 0) ? 1 : ((wyd[3:0] > 8) ? 8 : int'(wyd[3:0]));

      // a few more tags than ways over a few sets keeps hits and evictions mixed
      nt = eff_wy + $urandom_range(0, 3);
      ns = $urandom_range(1, 3);
      for (k = 0; k < nt; k++)
        tag_pool[k] = ($urandom_range(0, 2) == 0) ? {$urandom, $urandom}
                                                  : 64'($urandom_range(0, 15));
      for (k = 0; k < ns; k++)
        set_pool[k] = $urandom_range(0, (1 << eff_sb) - 1);

      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 2 && k == 5)
          push_ctl(OP_HOLD);
        if (ph == 5 && k == 35)
          push_ctl(OP_DRAIN);
        if ($urandom_range(0, 9) == 0)
          push_access({$urandom, $urandom});
        else
          push_access(compose_addr(tag_pool[$urandom_range(0, nt - 1)],
                                   set_pool[$urandom_range(0, ns - 1)],
                                   eff_sb + eff_ob, eff_ob));
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    while (op_q.size() != 0 || in_valid || results_seen != items_sent)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived",
                                pending_results.size()));

    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #5000000;
    $display("timeout: results stopped arriving");
    $display("end of test: mismatches");
    $finish;
  end

endmodule
